// ----- rtl/core/shmu_pkg.sv -----
`timescale 1ns / 1ps

package shmu_pkg;

  localparam int AMP_LEN = 12;
  localparam int THR_W   = 12;

  localparam logic [THR_W-1:0] THRESHOLD_RESET = 12'd50;
  localparam logic [5:0]       POS_MIN         = 6'd1;
  localparam logic [5:0]       POS_MAX         = 6'd31;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_READ   = 1'b1;

  typedef struct packed {
    logic        operation;
    logic        axis;
    logic [3:0]  strip;
    logic [11:0] amplitude;
    logic        event_last;
    logic [4:0]  bin_x;
    logic [4:0]  bin_y;
  } in_req_t;

  typedef struct packed {
    logic [4:0]  x_position;
    logic [4:0]  y_position;
    logic        x_found;
    logic        y_found;
    logic        map_filled;
    logic [31:0] bin_count;
  } out_req_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_UPDATE
  } state_t;

  typedef struct packed {
    logic clear_we;
    logic take;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic result_item;
    logic clear_last;
  } sts_t;

endpackage

// ----- rtl/core/shmu_ctrl.sv -----
`timescale 1ns / 1ps

module shmu_ctrl import shmu_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (sts.clear_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid && sts.result_item) state_nxt = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        if (slot_free) state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      ST_CLEAR: begin
        cmd.clear_we = 1'b1;
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.take = in_valid;
      end
      ST_LOOKUP: begin
        cmd = '0;
      end
      ST_UPDATE: begin
        cmd.commit = 1'b1;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // result slot must be empty when a result is loaded
  a_commit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> !out_valid_r)
    else $error("result loaded over a pending result");

  a_commit_gives_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid_r)
    else $error("result not presented after commit");

  a_lookup_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOOKUP && $past(state_r) == ST_IDLE) |-> $past(cmd.take))
    else $error("lookup started without a request");

endmodule

// ----- rtl/core/shmu_datapath.sv -----
`timescale 1ns / 1ps

module shmu_datapath import shmu_pkg::*; #(
  parameter int STRIP_COUNT    = 16,
  parameter int AMPLITUDE_BITS = 12,
  parameter int COUNTER_BITS   = 32,
  parameter int MAP_SIDE       = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  in_req_t          in_data,
  input  logic             cfg_we,
  input  logic [THR_W-1:0] cfg_data,
  input  cmd_t             cmd,
  output sts_t             sts,
  output out_req_t         out_data
);

  localparam int AMP_W     = (AMPLITUDE_BITS < AMP_LEN) ? AMPLITUDE_BITS : AMP_LEN;
  localparam int SW        = $clog2(STRIP_COUNT);
  localparam int MAP_WORDS = MAP_SIDE * MAP_SIDE;
  localparam int ADDR_W    = $clog2(MAP_WORDS);
  localparam logic [COUNTER_BITS-1:0] CNT_MAX = '1;

  logic [THR_W-1:0]       thr_r;
  logic [AMP_W-1:0]       peak_amp_r   [2];
  logic [SW-1:0]          peak_strip_r [2];
  logic                   peak_valid_r [2];
  logic [STRIP_COUNT-1:0] mask_r       [2];
  logic                   kind_read_r;
  logic [4:0]             bin_x_r, bin_y_r;
  logic [ADDR_W-1:0]      clr_addr_r;
  logic [COUNTER_BITS-1:0] map_mem [MAP_WORDS];
  logic [COUNTER_BITS-1:0] mem_q_r;
  out_req_t               out_data_r;

  logic [AMP_W-1:0]       amp_in;
  logic [SW-1:0]          strip_idx;
  logic                   strip_ok;
  logic                   above;
  logic                   wins;
  logic                   ax;
  logic [STRIP_COUNT-1:0] rgt_bits [2];
  logic [STRIP_COUNT-1:0] lft_bits [2];
  logic                   right    [2];
  logic                   left     [2];
  logic [5:0]             pos_raw  [2];
  logic [5:0]             pos_clip [2];
  logic [4:0]             pos      [2];
  logic                   hit_ok;
  logic                   rd_ok;
  logic                   filled;
  logic [ADDR_W-1:0]      ev_addr;
  logic [ADDR_W-1:0]      rd_addr;
  logic [ADDR_W-1:0]      map_addr;
  logic                   mem_we;
  logic [ADDR_W-1:0]      wr_addr;
  logic [COUNTER_BITS-1:0] wr_data;

  // sample qualification
  assign amp_in    = in_data.amplitude[AMP_W-1:0];
  assign strip_idx = in_data.strip[SW-1:0];
  assign strip_ok  = 5'(in_data.strip) < 5'(STRIP_COUNT);
  assign ax        = in_data.axis;
  assign above     = strip_ok && (THR_W'(amp_in) > thr_r);
  assign wins      = !peak_valid_r[ax] || (amp_in > peak_amp_r[ax]) ||
                     ((amp_in == peak_amp_r[ax]) && (strip_idx < peak_strip_r[ax]));

  // neighbor check and position
  for (genvar a = 0; a < 2; a++) begin : g_pos
    assign rgt_bits[a] = mask_r[a] >> 1;
    assign lft_bits[a] = mask_r[a] << 1;
    assign right[a]    = rgt_bits[a][peak_strip_r[a]];
    assign left[a]     = lft_bits[a][peak_strip_r[a]];

    always_comb begin
      if (right[a] && !left[a]) begin
        pos_raw[a] = (6'(peak_strip_r[a]) + 6'd1) << 1;
      end else if (left[a] && !right[a]) begin
        pos_raw[a] = 6'(peak_strip_r[a]) << 1;
      end else begin
        pos_raw[a] = (6'(peak_strip_r[a]) << 1) | 6'd1;
      end
      if (pos_raw[a] > POS_MAX) begin
        pos_clip[a] = POS_MAX;
      end else if (pos_raw[a] < POS_MIN) begin
        pos_clip[a] = POS_MIN;
      end else begin
        pos_clip[a] = pos_raw[a];
      end
      pos[a] = peak_valid_r[a] ? pos_clip[a][4:0] : 5'd0;
    end
  end

  assign hit_ok = peak_valid_r[0] && peak_valid_r[1] &&
                  (6'(pos[0]) < 6'(MAP_SIDE)) && (6'(pos[1]) < 6'(MAP_SIDE));
  assign rd_ok  = (6'(bin_x_r) < 6'(MAP_SIDE)) && (6'(bin_y_r) < 6'(MAP_SIDE));

  assign ev_addr  = ADDR_W'(11'(pos[0]) * 11'(MAP_SIDE) + 11'(pos[1]));
  assign rd_addr  = ADDR_W'(11'(bin_x_r) * 11'(MAP_SIDE) + 11'(bin_y_r));
  assign map_addr = kind_read_r ? rd_addr : ev_addr;

  assign filled  = !kind_read_r && hit_ok && (mem_q_r != CNT_MAX);
  assign mem_we  = cmd.clear_we || (cmd.commit && filled);
  assign wr_addr = cmd.clear_we ? clr_addr_r : map_addr;
  assign wr_data = cmd.clear_we ? '0 : mem_q_r + 1'b1;

  // hit map
  always_ff @(posedge clk) begin
    if (mem_we) map_mem[wr_addr] <= wr_data;
    mem_q_r <= map_mem[map_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clear_we) begin
      clr_addr_r <= clr_addr_r + 1'b1;
    end
  end

  assign sts.clear_last  = clr_addr_r == ADDR_W'(MAP_WORDS - 1);
  assign sts.result_item = (in_data.operation == OP_READ) || in_data.event_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THRESHOLD_RESET;
    end else if (cfg_we) begin
      thr_r <= cfg_data;
    end
  end

  // per-axis peak and mask
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < 2; a++) begin
        peak_amp_r[a]   <= '0;
        peak_strip_r[a] <= '0;
        peak_valid_r[a] <= 1'b0;
        mask_r[a]       <= '0;
      end
    end else if (cmd.take && in_data.operation == OP_SAMPLE && above) begin
      mask_r[ax] <= mask_r[ax] | (STRIP_COUNT'(1) << strip_idx);
      if (wins) begin
        peak_amp_r[ax]   <= amp_in;
        peak_strip_r[ax] <= strip_idx;
        peak_valid_r[ax] <= 1'b1;
      end
    end else if (cmd.commit && !kind_read_r) begin
      for (int a = 0; a < 2; a++) begin
        peak_amp_r[a]   <= '0;
        peak_strip_r[a] <= '0;
        peak_valid_r[a] <= 1'b0;
        mask_r[a]       <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      kind_read_r <= in_data.operation == OP_READ;
      bin_x_r     <= in_data.bin_x;
      bin_y_r     <= in_data.bin_y;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (kind_read_r) begin
        out_data_r.x_position <= '0;
        out_data_r.y_position <= '0;
        out_data_r.x_found    <= 1'b0;
        out_data_r.y_found    <= 1'b0;
        out_data_r.map_filled <= 1'b0;
        out_data_r.bin_count  <= rd_ok ? 32'(mem_q_r) : 32'd0;
      end else begin
        out_data_r.x_position <= pos[0];
        out_data_r.y_position <= pos[1];
        out_data_r.x_found    <= peak_valid_r[0];
        out_data_r.y_found    <= peak_valid_r[1];
        out_data_r.map_filled <= filled;
        out_data_r.bin_count  <= 32'd0;
      end
    end
  end

  assign out_data = out_data_r;

  a_event_clears_axes: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && !kind_read_r) |=> (!peak_valid_r[0] && !peak_valid_r[1]))
    else $error("axis state not cleared after event");

  a_read_keeps_axes: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && kind_read_r) |=> ($stable(mask_r[0]) && $stable(mask_r[1])))
    else $error("read disturbed event in progress");

  a_no_write_on_read: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && kind_read_r) |-> !mem_we)
    else $error("hit map written on a read");

endmodule

// ----- rtl/core/strip_hodoscope_hit_mapper_unit.sv -----
`timescale 1ns / 1ps

// channel   signals                           direction
// in        in_valid / in_stall / in_data     sample or bin read request in
// out       out_valid / out_stall / out_data  event result or bin count out
// cfg       cfg_valid / cfg_ready / cfg_data  hit threshold write
//
// a sample without event_last is taken while idle and needs no map lookup
// an event-ending sample or a bin read goes through accept, map lookup and
// map update; the lookup waits while the previous result is still held
// after reset a clearing pass writes MAP_SIDE*MAP_SIDE map bins, one per cycle
// (1024 by default), while in_stall stays high; cfg writes are taken throughout
// the map bin is read in the lookup state and, for an event, written back in the update state

module strip_hodoscope_hit_mapper_unit import shmu_pkg::*; #(
  parameter int STRIP_COUNT    = 16,
  parameter int AMPLITUDE_BITS = 12,
  parameter int COUNTER_BITS   = 32,
  parameter int MAP_SIDE       = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_req_t          in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_req_t         out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [THR_W-1:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  shmu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  shmu_datapath #(
    .STRIP_COUNT    (STRIP_COUNT),
    .AMPLITUDE_BITS (AMPLITUDE_BITS),
    .COUNTER_BITS   (COUNTER_BITS),
    .MAP_SIDE       (MAP_SIDE)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

// ----- tb/strip_hodoscope_hit_mapper_unit_test.sv -----
`timescale 1ns / 1ps

module strip_hodoscope_hit_mapper_unit_test;
  import shmu_pkg::*;

  localparam logic AXIS_X = 1'b0;
  localparam logic AXIS_Y = 1'b1;
  localparam int PHASES = 8;
  localparam int PHASE_REQUESTS = 212;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DRAIN_CYCLES = 8;
  localparam int IN_W = $bits(in_req_t);

  typedef struct packed {
    logic        retune;
    logic [11:0] level;
    in_req_t     req;
    logic        typed;
    out_req_t    want;
  } plan_row_t;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  in_req_t          in_data;
  logic             out_valid;
  logic             out_stall;
  out_req_t         out_data;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [THR_W-1:0] cfg_data;

  logic [11:0] threshold_q;
  logic [11:0] peak_amp [2];
  logic [3:0]  peak_strip [2];
  bit          peak_found [2];
  logic [15:0] above_mask [2];
  logic [31:0] hit_counts [1024];
  logic [9:0]  touched_bins [$];
  out_req_t    hit_reports [$];
  out_req_t    oldest_report;
  plan_row_t   plan [$];

  int failures = 0;
  int requests_sent = 0;
  int reports_checked = 0;
  int map_fills = 0;
  int retunes = 0;
  bit steady = 1'b0;
  bit hold_off_req = 1'b0;

  strip_hodoscope_hit_mapper_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #(5_000_000);
    $display("Test completed with failures");
    $finish;
  end

  function automatic in_req_t sample_req(logic ax, int s, int amp, logic last);
    in_req_t r;
    r = '0;
    r.operation = OP_SAMPLE;
    r.axis = ax;
    r.strip = 4'(s);
    r.amplitude = 12'(amp);
    r.event_last = last;
    return r;
  endfunction

  function automatic in_req_t read_req(int bx, int by);
    in_req_t r;
    r = '0;
    r.operation = OP_READ;
    r.bin_x = 5'(bx);
    r.bin_y = 5'(by);
    return r;
  endfunction

  function automatic out_req_t report(int xp, int yp, logic xf, logic yf, logic mf,
                                      logic [31:0] cnt);
    out_req_t o;
    o.x_position = 5'(xp);
    o.y_position = 5'(yp);
    o.x_found = xf;
    o.y_found = yf;
    o.map_filled = mf;
    o.bin_count = cnt;
    return o;
  endfunction

  function automatic logic [4:0] strip_position(int ax);
    logic [3:0] s;
    logic right, left;
    logic [5:0] p;
    s = peak_strip[ax];
    right = (s != 4'd15) && above_mask[ax][s + 4'd1];
    left = (s != 4'd0) && above_mask[ax][s - 4'd1];
    if (right && !left)
      p = 6'd2 * ({2'b00, s} + 6'd1);
    else if (left && !right)
      p = 6'd2 * {2'b00, s};
    else
      p = 6'd2 * {2'b00, s} + 6'd1;
    if (p > POS_MAX) p = POS_MAX;
    if (p < POS_MIN) p = POS_MIN;
    return p[4:0];
  endfunction

  task automatic locate_hit(in_req_t r);
    out_req_t o;
    logic [9:0] slot;
    int ax;
    o = '0;
    ax = int'(r.axis);
    if (r.operation == OP_READ) begin
      o.bin_count = hit_counts[{r.bin_x, r.bin_y}];
      hit_reports.push_back(o);
    end else begin
      if (r.amplitude > threshold_q) begin
        above_mask[ax][r.strip] = 1'b1;
        if (!peak_found[ax] || r.amplitude > peak_amp[ax] ||
            (r.amplitude == peak_amp[ax] && r.strip < peak_strip[ax])) begin
          peak_amp[ax] = r.amplitude;
          peak_strip[ax] = r.strip;
          peak_found[ax] = 1'b1;
        end
      end
      if (r.event_last) begin
        o.x_found = peak_found[0];
        o.y_found = peak_found[1];
        if (peak_found[0]) o.x_position = strip_position(0);
        if (peak_found[1]) o.y_position = strip_position(1);
        if (peak_found[0] && peak_found[1]) begin
          slot = {o.x_position, o.y_position};
          if (hit_counts[slot] != '1) begin
            hit_counts[slot] = hit_counts[slot] + 1;
            o.map_filled = 1'b1;
            touched_bins.push_back(slot);
            map_fills++;
          end
        end
        hit_reports.push_back(o);
        for (int a = 0; a < 2; a++) begin
          peak_amp[a] = '0;
          peak_strip[a] = '0;
          peak_found[a] = 1'b0;
          above_mask[a] = '0;
        end
      end
    end
  endtask

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (steady || roll < 45) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic offer_request(in_req_t r, logic typed = 1'b0, out_req_t want = '0);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_data = r;
    do @(posedge clk); while (in_stall);
    requests_sent++;
    locate_hit(r);
    if (typed) begin
      void'(hit_reports.pop_back());
      hit_reports.push_back(want);
    end
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (hit_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_threshold(logic [11:0] level);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data = level;
    do @(posedge clk); while (!cfg_ready);
    threshold_q = level;
    retunes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [11:0] quiet_amp();
    return 12'($urandom_range(0, int'(threshold_q)));
  endfunction

  function automatic logic [11:0] loud_amp();
    return 12'($urandom_range(int'(threshold_q) + 1, 4095));
  endfunction

  function automatic logic [11:0] strip_amp(bit lit, int mid, logic [11:0] peak, int s);
    int d;
    int roll;
    d = (s > mid) ? s - mid : mid - s;
    roll = $urandom_range(0, 99);
    if (!lit) return quiet_amp();
    if (d == 0) return peak;
    if (d == 1) begin
      if (roll < 20) return peak;
      if (roll < 65) return loud_amp();
      return quiet_amp();
    end
    if (d == 2 && roll < 30) return loud_amp();
    if (roll < 8) return loud_amp();
    return quiet_amp();
  endfunction

  // one event with a cluster around a random strip on each lit plane
  task automatic shoot_event();
    bit full_scan;
    bit lit [2];
    int mid [2];
    logic [11:0] peak [2];
    int n, ax, s, first;
    in_req_t r;
    full_scan = ($urandom_range(0, 99) < 35);
    for (int a = 0; a < 2; a++) begin
      lit[a] = ($urandom_range(0, 9) != 0);
      mid[a] = $urandom_range(0, 15);
      peak[a] = loud_amp();
    end
    if (full_scan) begin
      first = $urandom_range(0, 1);
      for (int k = 0; k < 32; k++) begin
        ax = (k < 16) ? first : 1 - first;
        s = k % 16;
        r = sample_req(1'(ax), s, strip_amp(lit[ax], mid[ax], peak[ax], s), k == 31);
        r.bin_x = 5'($urandom);
        r.bin_y = 5'($urandom);
        offer_request(r);
      end
    end else begin
      n = $urandom_range(2, 8);
      for (int k = 0; k < n; k++) begin
        ax = $urandom_range(0, 1);
        if ($urandom_range(0, 4) == 0)
          s = $urandom_range(0, 15);
        else
          s = mid[ax] + $urandom_range(0, 4) - 2;
        if (s < 0) s = 0;
        if (s > 15) s = 15;
        r = sample_req(1'(ax), s, strip_amp(lit[ax], mid[ax], peak[ax], s), k == n - 1);
        r.bin_x = 5'($urandom);
        r.bin_y = 5'($urandom);
        offer_request(r);
      end
    end
  endtask

  task automatic probe_bin();
    in_req_t r;
    logic [9:0] slot;
    r = IN_W'($urandom);
    r.operation = OP_READ;
    if (touched_bins.size() != 0 && $urandom_range(0, 9) < 7)
      slot = touched_bins[$urandom_range(0, touched_bins.size() - 1)];
    else
      slot = 10'($urandom);
    {r.bin_x, r.bin_y} = slot;
    offer_request(r);
  endtask

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && !out_stall) begin
      if (hit_reports.size() == 0) begin
        $error("result with nothing outstanding: %h", out_data);
        failures++;
      end else begin
        oldest_report = hit_reports.pop_front();
        check_field("x_position", 32'(oldest_report.x_position),
                    32'(out_data.x_position));
        check_field("y_position", 32'(oldest_report.y_position),
                    32'(out_data.y_position));
        check_field("x_found", 32'(oldest_report.x_found), 32'(out_data.x_found));
        check_field("y_found", 32'(oldest_report.y_found), 32'(out_data.y_found));
        check_field("map_filled", 32'(oldest_report.map_filled),
                    32'(out_data.map_filled));
        check_field("bin_count", oldest_report.bin_count, out_data.bin_count);
        reports_checked++;
      end
    end
  end

  initial begin
    int stall_len;
    out_stall = 1'b0;
    forever begin
      if (hold_off_req) begin
        @(negedge clk);
        out_stall = 1'b1;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        out_stall = 1'b0;
        hold_off_req = 1'b0;
      end else begin
        @(negedge clk);
        stall_len = pick_gap();
        if (stall_len > 0) begin
          out_stall = 1'b1;
          repeat (stall_len) @(negedge clk);
          out_stall = 1'b0;
        end
      end
    end
  end

  initial begin
    logic [11:0] level;
    int goal;
    int roll;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    threshold_q = THRESHOLD_RESET;
    for (int a = 0; a < 2; a++) begin
      peak_amp[a] = '0;
      peak_strip[a] = '0;
      peak_found[a] = 1'b0;
      above_mask[a] = '0;
    end
    foreach (hit_counts[i]) hit_counts[i] = '0;

    plan = '{
      '{1'b0, 12'd0, read_req(0, 0), 1'b1, report(0, 0, 0, 0, 0, 0)},
      '{1'b0, 12'd0, read_req(31, 31), 1'b1, report(0, 0, 0, 0, 0, 0)},
      '{1'b0, 12'd0, sample_req(AXIS_X, 0, 50, 1), 1'b1, report(0, 0, 0, 0, 0, 0)},
      '{1'b0, 12'd0, sample_req(AXIS_X, 0, 4095, 0), 1'b0, '0},
      '{1'b0, 12'd0, sample_req(AXIS_Y, 15, 4095, 1), 1'b1, report(1, 31, 1, 1, 1, 0)},
      '{1'b0, 12'd0, read_req(1, 31), 1'b1, report(0, 0, 0, 0, 0, 1)},
      '{1'b0, 12'd0, sample_req(AXIS_X, 3, 200, 0), 1'b0, '0},
      '{1'b0, 12'd0, sample_req(AXIS_X, 4, 300, 0), 1'b0, '0},
      '{1'b0, 12'd0, sample_req(AXIS_X, 5, 100, 0), 1'b0, '0},
      '{1'b0, 12'd0, sample_req(AXIS_Y, 8, 600, 0), 1'b0, '0},
      '{1'b0, 12'd0, sample_req(AXIS_Y, 7, 600, 0), 1'b0, '0},
      '{1'b0, 12'd0, sample_req(AXIS_Y, 7, 10, 0), 1'b0, '0},
      '{1'b0, 12'd0, sample_req(AXIS_X, 4, 300, 1), 1'b0, '0},
      '{1'b0, 12'd0, read_req(9, 16), 1'b0, '0},
      '{1'b0, 12'd0, sample_req(AXIS_X, 10, 900, 0), 1'b0, '0},
      '{1'b0, 12'd0, sample_req(AXIS_X, 9, 100, 0), 1'b0, '0},
      '{1'b0, 12'd0, sample_req(AXIS_Y, 1, 4095, 1), 1'b0, '0},
      '{1'b1, 12'd4095, sample_req(AXIS_X, 0, 4095, 1), 1'b1, report(0, 0, 0, 0, 0, 0)},
      '{1'b1, 12'd0, sample_req(AXIS_X, 0, 1, 0), 1'b0, '0},
      '{1'b0, 12'd0, sample_req(AXIS_Y, 0, 0, 1), 1'b1, report(1, 0, 1, 0, 0, 0)},
      '{1'b0, 12'd0, sample_req(AXIS_X, 6, 5, 0), 1'b0, '0},
      // threshold raised while the event is still open
      '{1'b1, 12'd100, sample_req(AXIS_X, 7, 50, 0), 1'b0, '0},
      '{1'b0, 12'd0, sample_req(AXIS_Y, 2, 200, 1), 1'b0, '0},
      '{1'b0, 12'd0, read_req(13, 5), 1'b0, '0}
    };

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (plan[i]) begin
      if (plan[i].retune) begin
        settle();
        set_threshold(plan[i].level);
      end
      offer_request(plan[i].req, plan[i].typed, plan[i].want);
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      settle();
      case (phase % 4)
        0: level = 12'($urandom_range(0, 4000));
        1: level = 12'($urandom_range(0, 120));
        2: level = THRESHOLD_RESET;
        default: level = 12'($urandom_range(1000, 4000));
      endcase
      set_threshold(level);
      steady = (phase == 3);
      // long receiver hold-off so the block backs up into its input
      if (phase == 1) hold_off_req = 1'b1;
      goal = requests_sent + PHASE_REQUESTS;
      while (requests_sent < goal) begin
        roll = $urandom_range(0, 99);
        if (roll < 60)
          shoot_event();
        else if (roll < 85)
          probe_bin();
        else
          offer_request(in_req_t'(IN_W'($urandom)));
      end
    end
    steady = 1'b0;
    settle();

    $display("%0d requests sent, %0d results checked, %0d hit-map increments",
             requests_sent, reports_checked, map_fills);
    $display("%0d threshold settings used, from 0 to 4095, with open events and reads mixed in",
             retunes);
    if (failures == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/shmu_pkg.sv
rtl/core/shmu_ctrl.sv
rtl/core/shmu_datapath.sv
rtl/core/strip_hodoscope_hit_mapper_unit.sv
tb/strip_hodoscope_hit_mapper_unit_test.sv
